// ===== sv/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants for the disk request scheduler
// Word layouts, operation and register codes, and controller states.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int TRACK_W = 9;
  localparam int ID_W    = 8;
  localparam int TOTAL_W = 16;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TRACK_BITS_DEF  = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [TRACK_W-1:0] START_TRACK_RST = 9'd90;

  typedef enum logic [1:0] {
    MODE_ENQUEUE  = 2'd0,
    MODE_DISPATCH = 2'd1,
    MODE_RESTART  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SSTF = 2'd1,
    POL_SCAN = 2'd2
  } policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY       = 2'd0,
    REG_START_TRACK  = 2'd1,
    REG_START_UPWARD = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ID_W-1:0]    request_id;
    logic [TRACK_W-1:0] request_track;
  } in_word_t;

  typedef struct packed {
    logic               served;
    logic [ID_W-1:0]    served_id;
    logic [TRACK_W-1:0] served_track;
    logic [TRACK_W-1:0] seek_distance;
    logic [TOTAL_W-1:0] total_moves;
    logic               queue_empty;
    logic               enqueue_dropped;
  } out_word_t;

endpackage

// ===== sv/disk_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// disk_request_scheduler: pending track request table with FCFS, shortest
// seek and elevator dispatch, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel   ports                           handshake
//  input     start, busy, in_data            taken when start && !busy
//  result    out_valid, out_data             one-cycle strobe, no backpressure
//  config    cfg_we, cfg_index, cfg_wdata    written when cfg_we is high
//
//  Enqueue, restart, an unknown mode and a dispatch on an empty table leave
//  busy low; the result word strobes on the next cycle. A dispatch on a
//  nonempty table keeps busy high while it scans the table through the
//  single RAM read port, picks the entry and shifts the rest up.
//  Its result strobes after the pick cycle.
//  Reset is synchronous; the table needs no clearing pass. The receiver
//  cannot stall results.
// ----------------------------------------------------------------------------
module disk_request_scheduler #(
  parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
  parameter int TRACK_BITS  = drs_pkg::TRACK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  drs_pkg::in_word_t             in_data,
  output logic                          out_valid,
  output drs_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [drs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = drs_pkg::ID_W + TRACK_BITS;
  localparam int SUM_W = drs_pkg::TOTAL_W + 1;

  localparam logic [drs_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  // request table: {id, track}
  logic [ENT_W-1:0] mem [QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_q_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  drs_pkg::state_t state_r, state_nxt;

  logic [1:0]            policy_r;
  logic [TRACK_BITS-1:0] start_track_r;
  logic                  start_up_r;

  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [TRACK_BITS-1:0]       head_r, head_nxt;
  logic                        moving_up_r, moving_up_nxt;
  logic [drs_pkg::TOTAL_W-1:0] total_r, total_nxt;

  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  found_up_r, found_up_nxt;
  logic                  found_dn_r, found_dn_nxt;
  logic [TRACK_BITS-1:0] best_up_r, best_up_nxt;
  logic [TRACK_BITS-1:0] best_dn_r, best_dn_nxt;
  logic [TRACK_BITS-1:0] best_any_r, best_any_nxt;
  logic [IDX_W-1:0]      pos_up_r, pos_up_nxt;
  logic [IDX_W-1:0]      pos_dn_r, pos_dn_nxt;
  logic [IDX_W-1:0]      pos_any_r, pos_any_nxt;
  logic [ENT_W-1:0]      ent_up_r, ent_up_nxt;
  logic [ENT_W-1:0]      ent_dn_r, ent_dn_nxt;
  logic [ENT_W-1:0]      ent_any_r, ent_any_nxt;
  logic [ENT_W-1:0]      ent0_r, ent0_nxt;
  logic [IDX_W-1:0]      sel_pos_r, sel_pos_nxt;

  logic               out_valid_r, out_valid_nxt;
  drs_pkg::out_word_t out_data_r, out_data_nxt;

  logic                  accept;
  logic                  full;
  logic                  idx_last;
  logic [TRACK_BITS-1:0] rd_track;
  logic [TRACK_BITS-1:0] rd_dist;
  logic                  cand_up;
  logic                  cand_dn;
  logic [ENT_W-1:0]      sel_ent;
  logic [IDX_W-1:0]      sel_pos;
  logic                  sel_mu;
  logic [TRACK_BITS-1:0] sel_track;
  logic [TRACK_BITS-1:0] sel_dist;
  logic [SUM_W-1:0]      sum;

  assign busy      = (state_r != drs_pkg::ST_IDLE);
  assign accept    = start && (state_r == drs_pkg::ST_IDLE);
  assign full      = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign idx_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // scan compare on the word read last cycle
  assign rd_track = rd_q_r[TRACK_BITS-1:0];
  assign rd_dist  = (rd_track >= head_r) ? (rd_track - head_r) : (head_r - rd_track);
  assign cand_up  = (rd_track >= head_r);
  assign cand_dn  = (rd_track <= head_r);

  // pick the entry to serve from the scan results
  always_comb begin
    sel_ent = ent0_r;
    sel_pos = '0;
    sel_mu  = moving_up_r;
    case (policy_r)
      drs_pkg::POL_SSTF: begin
        sel_ent = ent_any_r;
        sel_pos = pos_any_r;
      end
      drs_pkg::POL_SCAN: begin
        if (moving_up_r) begin
          if (found_up_r) begin
            sel_ent = ent_up_r;
            sel_pos = pos_up_r;
          end else begin
            sel_ent = ent_dn_r;
            sel_pos = pos_dn_r;
            sel_mu  = 1'b0;
          end
        end else begin
          if (found_dn_r) begin
            sel_ent = ent_dn_r;
            sel_pos = pos_dn_r;
          end else begin
            sel_ent = ent_up_r;
            sel_pos = pos_up_r;
            sel_mu  = 1'b1;
          end
        end
      end
      default: begin
        sel_ent = ent0_r;
        sel_pos = '0;
      end
    endcase
  end

  assign sel_track = sel_ent[TRACK_BITS-1:0];
  assign sel_dist  = (sel_track >= head_r) ? (sel_track - head_r) : (head_r - sel_track);
  assign sum       = SUM_W'(total_r) + SUM_W'(sel_dist);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drs_pkg::ST_IDLE: begin
        if (accept && (in_data.mode == drs_pkg::MODE_DISPATCH) && (count_r != '0)) begin
          state_nxt = drs_pkg::ST_SCAN;
        end
      end
      drs_pkg::ST_SCAN: begin
        if (idx_last) begin
          state_nxt = drs_pkg::ST_DECIDE;
        end
      end
      drs_pkg::ST_DECIDE: begin
        state_nxt = (count_r > CNT_W'(1)) ? drs_pkg::ST_SHIFT : drs_pkg::ST_IDLE;
      end
      drs_pkg::ST_SHIFT: begin
        if (idx_last) begin
          state_nxt = drs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = drs_pkg::ST_IDLE;
    endcase
  end

  // datapath, RAM port and result word
  always_comb begin
    count_nxt     = count_r;
    head_nxt      = head_r;
    moving_up_nxt = moving_up_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    found_up_nxt  = found_up_r;
    found_dn_nxt  = found_dn_r;
    best_up_nxt   = best_up_r;
    best_dn_nxt   = best_dn_r;
    best_any_nxt  = best_any_r;
    pos_up_nxt    = pos_up_r;
    pos_dn_nxt    = pos_dn_r;
    pos_any_nxt   = pos_any_r;
    ent_up_nxt    = ent_up_r;
    ent_dn_nxt    = ent_dn_r;
    ent_any_nxt   = ent_any_r;
    ent0_nxt      = ent0_r;
    sel_pos_nxt   = sel_pos_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = {in_data.request_id, TRACK_BITS'(in_data.request_track)};
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;

    case (state_r)
      drs_pkg::ST_IDLE: begin
        idx_nxt      = '0;
        found_up_nxt = 1'b0;
        found_dn_nxt = 1'b0;
        if (accept) begin
          case (in_data.mode)
            drs_pkg::MODE_ENQUEUE: begin
              if (!full) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            drs_pkg::MODE_RESTART: begin
              count_nxt     = '0;
              head_nxt      = start_track_r;
              moving_up_nxt = start_up_r;
              total_nxt     = '0;
            end
            default: ;
          endcase
          // a dispatch on a nonempty table reports after the scan
          if (!((in_data.mode == drs_pkg::MODE_DISPATCH) && (count_r != '0))) begin
            out_valid_nxt                = 1'b1;
            out_data_nxt.total_moves     = total_nxt;
            out_data_nxt.queue_empty     = (count_nxt == '0);
            out_data_nxt.enqueue_dropped = (in_data.mode == drs_pkg::MODE_ENQUEUE) && full;
          end
        end
      end
      drs_pkg::ST_SCAN: begin
        rd_addr = idx_r + IDX_W'(1);
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == '0) begin
          ent0_nxt = rd_q_r;
        end
        if ((idx_r == '0) || (rd_dist <= best_any_r)) begin
          best_any_nxt = rd_dist;
          pos_any_nxt  = idx_r;
          ent_any_nxt  = rd_q_r;
        end
        if (cand_up && (!found_up_r || (rd_dist <= best_up_r))) begin
          found_up_nxt = 1'b1;
          best_up_nxt  = rd_dist;
          pos_up_nxt   = idx_r;
          ent_up_nxt   = rd_q_r;
        end
        if (cand_dn && (!found_dn_r || (rd_dist <= best_dn_r))) begin
          found_dn_nxt = 1'b1;
          best_dn_nxt  = rd_dist;
          pos_dn_nxt   = idx_r;
          ent_dn_nxt   = rd_q_r;
        end
        if (idx_last) begin
          idx_nxt = '0;
        end
      end
      drs_pkg::ST_DECIDE: begin
        // prefetch entry 1 for the shift
        rd_addr       = IDX_W'(1);
        idx_nxt       = '0;
        sel_pos_nxt   = sel_pos;
        moving_up_nxt = sel_mu;
        head_nxt      = sel_track;
        count_nxt     = count_r - CNT_W'(1);
        total_nxt     = sum[SUM_W-1] ? TOTAL_MAX : sum[drs_pkg::TOTAL_W-1:0];
        out_valid_nxt                = 1'b1;
        out_data_nxt.served          = 1'b1;
        out_data_nxt.served_id       = sel_ent[ENT_W-1 -: drs_pkg::ID_W];
        out_data_nxt.served_track    = drs_pkg::TRACK_W'(sel_track);
        out_data_nxt.seek_distance   = drs_pkg::TRACK_W'(sel_dist);
        out_data_nxt.total_moves     = total_nxt;
        out_data_nxt.queue_empty     = (count_r == CNT_W'(1));
        out_data_nxt.enqueue_dropped = 1'b0;
      end
      drs_pkg::ST_SHIFT: begin
        // move entry k+1 to k; the old head takes the chosen slot
        rd_addr = idx_r + IDX_W'(2);
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = ((idx_r + IDX_W'(1)) == sel_pos_r) ? ent0_r : rd_q_r;
        idx_nxt = idx_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= drs_pkg::ST_IDLE;
      policy_r      <= drs_pkg::POL_FCFS;
      start_track_r <= TRACK_BITS'(drs_pkg::START_TRACK_RST);
      start_up_r    <= 1'b1;
      count_r       <= '0;
      head_r        <= TRACK_BITS'(drs_pkg::START_TRACK_RST);
      moving_up_r   <= 1'b1;
      total_r       <= '0;
      idx_r         <= '0;
      found_up_r    <= 1'b0;
      found_dn_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      moving_up_r <= moving_up_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      found_up_r  <= found_up_nxt;
      found_dn_r  <= found_dn_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          drs_pkg::REG_POLICY:       policy_r      <= cfg_wdata[1:0];
          drs_pkg::REG_START_TRACK:  start_track_r <= TRACK_BITS'(cfg_wdata);
          drs_pkg::REG_START_UPWARD: start_up_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_up_r  <= best_up_nxt;
    best_dn_r  <= best_dn_nxt;
    best_any_r <= best_any_nxt;
    pos_up_r   <= pos_up_nxt;
    pos_dn_r   <= pos_dn_nxt;
    pos_any_r  <= pos_any_nxt;
    ent_up_r   <= ent_up_nxt;
    ent_dn_r   <= ent_dn_nxt;
    ent_any_r  <= ent_any_nxt;
    ent0_r     <= ent0_nxt;
    sel_pos_r  <= sel_pos_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sim/tb_disk_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_disk_request_scheduler: self-checking bench for the disk request scheduler
// Drives enqueue, dispatch and restart words under every dispatch policy,
// predicts each result word from a behavioral copy of the request table and
// compares all result fields in arrival order.
// ----------------------------------------------------------------------------
module tb_disk_request_scheduler;

  localparam int QDEPTH      = drs_pkg::QUEUE_DEPTH_DEF;
  localparam int SETTLE      = 2 * QDEPTH + 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 195;
  localparam int SAT_PAIRS   = 140;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] POL_UNUSED  = 2'd3;

  typedef enum int {ANY_SIDE, AT_OR_ABOVE, AT_OR_BELOW} side_t;

  class seek_scoreboard;
    logic [drs_pkg::TRACK_W-1:0] track_tab [QDEPTH];
    logic [drs_pkg::ID_W-1:0]    id_tab [QDEPTH];
    int unsigned                 fill;
    logic [drs_pkg::TRACK_W-1:0] head;
    bit                          up;
    int unsigned                 total;
    logic [1:0]                  policy;
    logic [drs_pkg::TRACK_W-1:0] home_track;
    bit                          home_up;
    drs_pkg::out_word_t          due_results[$];
    int                          errors;
    int                          accepted;
    int                          checked;
    int                          drops;
    int                          saturated;

    function new();
      fill       = 0;
      head       = drs_pkg::START_TRACK_RST;
      up         = 1'b1;
      total      = 0;
      policy     = drs_pkg::POL_FCFS;
      home_track = drs_pkg::START_TRACK_RST;
      home_up    = 1'b1;
      errors     = 0;
      accepted   = 0;
      checked    = 0;
      drops      = 0;
      saturated  = 0;
    endfunction

    function void note_config(drs_pkg::cfg_reg_t idx,
                              logic [drs_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        drs_pkg::REG_POLICY:       policy = value[1:0];
        drs_pkg::REG_START_TRACK:  home_track = value[drs_pkg::TRACK_W-1:0];
        drs_pkg::REG_START_UPWARD: home_up = value[0];
        default: ;
      endcase
    endfunction

    // ties resolve to the latest table position
    function bit find_nearest(side_t side, output int pos);
      bit                          found;
      logic [drs_pkg::TRACK_W-1:0] best;
      logic [drs_pkg::TRACK_W-1:0] d;
      logic [drs_pkg::TRACK_W-1:0] t;
      found = 1'b0;
      best  = '0;
      pos   = 0;
      for (int i = 0; i < fill; i++) begin
        t = track_tab[i];
        if (side == AT_OR_ABOVE && t < head) continue;
        if (side == AT_OR_BELOW && t > head) continue;
        d = (t >= head) ? t - head : head - t;
        if (!found || d <= best) begin
          found = 1'b1;
          best  = d;
          pos   = i;
        end
      end
      return found;
    endfunction

    function int pick_entry();
      int pos;
      pos = 0;
      case (policy)
        drs_pkg::POL_SSTF: void'(find_nearest(ANY_SIDE, pos));
        drs_pkg::POL_SCAN: begin
          if (up) begin
            if (!find_nearest(AT_OR_ABOVE, pos)) begin
              up = 1'b0;
              void'(find_nearest(AT_OR_BELOW, pos));
            end
          end else begin
            if (!find_nearest(AT_OR_BELOW, pos)) begin
              up = 1'b1;
              void'(find_nearest(AT_OR_ABOVE, pos));
            end
          end
        end
        default: pos = 0;
      endcase
      return pos;
    endfunction

    function void note_request(drs_pkg::in_word_t w);
      drs_pkg::out_word_t          e;
      int                          j;
      logic [drs_pkg::TRACK_W-1:0] seek_len;
      e = '0;
      accepted++;
      case (w.mode)
        drs_pkg::MODE_ENQUEUE: begin
          if (fill >= QDEPTH) begin
            e.enqueue_dropped = 1'b1;
          end else begin
            track_tab[fill] = w.request_track;
            id_tab[fill]    = w.request_id;
            fill++;
          end
        end
        drs_pkg::MODE_DISPATCH: begin
          if (fill > 0) begin
            j = pick_entry();
            e.served       = 1'b1;
            e.served_id    = id_tab[j];
            e.served_track = track_tab[j];
            // swap the pick into the head slot, then shift the rest up
            id_tab[j]    = id_tab[0];
            track_tab[j] = track_tab[0];
            for (int i = 1; i < fill; i++) begin
              id_tab[i-1]    = id_tab[i];
              track_tab[i-1] = track_tab[i];
            end
            fill--;
            seek_len = (e.served_track >= head) ? e.served_track - head
                                                : head - e.served_track;
            total = total + seek_len;
            if (total > 65535) total = 65535;
            head = e.served_track;
            e.seek_distance = seek_len;
          end
        end
        drs_pkg::MODE_RESTART: begin
          fill  = 0;
          head  = home_track;
          up    = home_up;
          total = 0;
        end
        default: ;
      endcase
      e.total_moves = total[drs_pkg::TOTAL_W-1:0];
      e.queue_empty = (fill == 0);
      due_results = {due_results, e};
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(drs_pkg::out_word_t got);
      drs_pkg::out_word_t want;
      if (due_results.size() == 0) begin
        $error("result word with nothing outstanding: %p", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (want.enqueue_dropped) drops++;
      if (want.total_moves == '1) saturated++;
      compare_field("served", 16'(want.served), 16'(got.served));
      compare_field("served_id", 16'(want.served_id), 16'(got.served_id));
      compare_field("served_track", 16'(want.served_track), 16'(got.served_track));
      compare_field("seek_distance", 16'(want.seek_distance), 16'(got.seek_distance));
      compare_field("total_moves", 16'(want.total_moves), 16'(got.total_moves));
      compare_field("queue_empty", 16'(want.queue_empty), 16'(got.queue_empty));
      compare_field("enqueue_dropped", 16'(want.enqueue_dropped),
                    16'(got.enqueue_dropped));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  drs_pkg::in_word_t              in_data = '0;
  logic                           out_valid;
  drs_pkg::out_word_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [drs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [drs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  seek_scoreboard sb = new();
  int idle_pct = 0;

  disk_request_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[disk_request_scheduler] ERROR");
    $finish;
  end

  function automatic drs_pkg::in_word_t make_word(logic [1:0] m,
                                                  logic [drs_pkg::ID_W-1:0] id,
                                                  logic [drs_pkg::TRACK_W-1:0] trk);
    drs_pkg::in_word_t w;
    w.mode          = m;
    w.request_id    = id;
    w.request_track = trk;
    return w;
  endfunction

  // hold start until the word is taken, with optional idle cycles first
  task automatic send_word(drs_pkg::in_word_t w);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(w);
  endtask

  // drop start and wait out every outstanding result plus the shift tail
  task automatic drain();
    start <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] pol, logic [drs_pkg::TRACK_W-1:0] trk,
                              bit upward);
    drs_pkg::cfg_reg_t              idx;
    logic [drs_pkg::CFG_DATA_W-1:0] value;
    for (int k = 0; k < 3; k++) begin
      idx   = drs_pkg::cfg_reg_t'(k);
      value = (idx == drs_pkg::REG_POLICY) ? drs_pkg::CFG_DATA_W'(pol) :
              (idx == drs_pkg::REG_START_TRACK) ? drs_pkg::CFG_DATA_W'(trk) :
              drs_pkg::CFG_DATA_W'(upward);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= value;
      @(posedge clk);
      sb.note_config(idx, value);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int n_words);
    drs_pkg::in_word_t w;
    int                done;
    int                r;
    bit                filling;
    done    = 0;
    filling = 1'b1;
    while (done < n_words) begin
      r = $urandom_range(0, 99);
      if (sb.fill == QDEPTH && $urandom_range(0, 3) != 0) filling = 1'b0;
      else if (sb.fill == 0 && $urandom_range(0, 3) != 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 4) filling = !filling;
      w.request_id = drs_pkg::ID_W'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0:       w.request_track = drs_pkg::TRACK_W'($urandom_range(0, 511));
        1:       w.request_track = drs_pkg::TRACK_W'(sb.head + $urandom_range(0, 6) - 3);
        2:       w.request_track = $urandom_range(0, 1) ? 9'd511 : 9'd0;
        default: w.request_track = drs_pkg::TRACK_W'($urandom_range(0, 7) * 73);
      endcase
      if (r < 2) w.mode = drs_pkg::MODE_RESTART;
      else if (r < 4) w.mode = MODE_UNUSED;
      else if ((filling && r < 72) || (!filling && r < 32)) w.mode = drs_pkg::MODE_ENQUEUE;
      else w.mode = drs_pkg::MODE_DISPATCH;
      if (w.mode != MODE_UNUSED) done++;
      if ($urandom_range(0, 99) < 2) drain();
      send_word(w);
    end
  endtask

  initial begin : main
    int                          pct_by_phase [4];
    logic [1:0]                  pol;
    logic [drs_pkg::TRACK_W-1:0] home;
    pct_by_phase = '{0, 76, 0, 31};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unknown mode, restart, then six enqueues
    send_word(make_word(drs_pkg::MODE_DISPATCH, 8'h00, 9'd0));
    send_word(make_word(MODE_UNUSED, 8'hFF, 9'd511));
    send_word(make_word(drs_pkg::MODE_RESTART, 8'h00, 9'd0));
    send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'h00, 9'd0));
    send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'hFF, 9'd511));
    send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'h11, 9'd90));
    send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'h22, 9'd90));
    send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'h33, 9'd100));
    send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'h44, 9'd80));
    drain();
    // shortest seek: duplicate at the head, then an equal-distance tie
    write_config(drs_pkg::POL_SSTF, drs_pkg::START_TRACK_RST, 1'b1);
    repeat (3) send_word(make_word(drs_pkg::MODE_DISPATCH, 8'h00, 9'd0));
    drain();
    // elevator upward, reversal, then dispatch on an empty table
    write_config(drs_pkg::POL_SCAN, drs_pkg::START_TRACK_RST, 1'b1);
    repeat (4) send_word(make_word(drs_pkg::MODE_DISPATCH, 8'h00, 9'd0));
    drain();
    // undefined policy behaves as first come first served
    write_config(POL_UNUSED, 9'd511, 1'b0);
    send_word(make_word(drs_pkg::MODE_RESTART, 8'h00, 9'd0));
    send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'h5A, 9'd300));
    send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'hA5, 9'd511));
    repeat (2) send_word(make_word(drs_pkg::MODE_DISPATCH, 8'h00, 9'd0));
    drain();

    // full-stroke seeks to push the running total into saturation
    write_config(drs_pkg::POL_FCFS, 9'd0, 1'b1);
    send_word(make_word(drs_pkg::MODE_RESTART, 8'h00, 9'd0));
    for (int k = 0; k < SAT_PAIRS; k++) begin
      send_word(make_word(drs_pkg::MODE_ENQUEUE, 8'($urandom_range(0, 255)),
                          k[0] ? 9'd0 : 9'd511));
      send_word(make_word(drs_pkg::MODE_DISPATCH, 8'($urandom_range(0, 255)), 9'd0));
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      pol  = 2'(p % 4);
      home = (p == 0) ? 9'd0 : (p == 1) ? 9'd511 : 9'($urandom_range(0, 511));
      idle_pct = pct_by_phase[(p / 2) % 4];
      write_config(pol, home, 1'((p >> 2) & 1));
      send_word(make_word(drs_pkg::MODE_RESTART, 8'($urandom_range(0, 255)), 9'd0));
      run_phase(PHASE_WORDS);
      drain();
    end

    $display("Covered %0d request words across all four policy codes, restarts, full",
             sb.accepted);
    $display("and empty tables; %0d results checked, %0d dropped, %0d saturated totals.",
             sb.checked, sb.drops, sb.saturated);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("[disk_request_scheduler] OK");
    end else begin
      $display("[disk_request_scheduler] ERROR");
    end
    $finish;
  end

endmodule
